### hdl/fifo_with_key_removal_macros.svh
// Assertion macros for the record queue with row removal.
// Used by fifo_with_key_removal.sv; expects clk and rst in scope.
`ifndef FIFO_WITH_KEY_REMOVAL_MACROS_SVH
`define FIFO_WITH_KEY_REMOVAL_MACROS_SVH

// Same-cycle implication, held off during reset
`define FKR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fkr: same-cycle check failed");

// Next-cycle implication, held off during reset
`define FKR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fkr: next-cycle check failed");

`endif

### hdl/fkr_pkg.sv
// Shared types and codes for the record queue with row removal.
// No dependencies; imported by fkr_store and fifo_with_key_removal.
package fkr_pkg;

  localparam int DEPTH_DEF = 64;

  // Request codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // One stored record: row, column, size
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  len;
  } rec_t;

  // Memory port strobes from the controller to the store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### hdl/fkr_store.sv
// Record store: one write port, one read port, registered read data.
// Depends on fkr_pkg for rec_t and mem_ctl_t.
module fkr_store
  import fkr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [DEPTH];

  // Write; read data is registered, valid the cycle after rd_en
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/fifo_with_key_removal.sv
// Channel   | Signals                                         | Handshake
// request   | req_type item_row item_col item_len match_row   | start && !busy
// result    | entry_count removed_count push_dropped pop_empty| done, one cycle
//
// Push, pop and no-op requests never enter the walk: the result strobes on the
// cycle after the request, and busy stays low, so a new request may follow.
// A row removal reads the held records one per cycle through the store's
// single read port and writes kept ones back compacted: busy is high through
// the walk and the result strobes as busy falls. A removal on an empty queue
// skips the walk and answers as a pop does.
// Reset (rst, synchronous) empties the queue; the store itself is not cleared.
// The receiver cannot stall; busy holds off requests only during a removal.
//
// Depends on fkr_pkg, fkr_store and fifo_with_key_removal_macros.svh.
`include "fifo_with_key_removal_macros.svh"

module fifo_with_key_removal
  import fkr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] item_row,
  input  logic signed [15:0] item_col,
  input  logic [7:0]         item_len,
  input  logic signed [15:0] match_row,
  output logic               done,
  output logic [6:0]         entry_count,
  output logic [6:0]         removed_count,
  output logic               push_dropped,
  output logic               pop_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t        state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] kept;
  logic [CW-1:0] removed;
  logic          pend;
  logic [15:0]   key;
  logic          full;

  mem_ctl_t      mctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rec_t          wdata;
  rec_t          rdata;

  // Slot of the record at a given offset from the head, wrapped at DEPTH
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full = (count == FULL);
  assign busy = (state == S_WALK);

  // Drive the store: tail write on push, walk reads and compacting writes.
  // Writes go to offset kept, never ahead of the next read offset, so a walk
  // read never meets a slot rewritten earlier in the same walk.
  always_comb begin
    mctl  = '0;
    waddr = '0;
    raddr = '0;
    wdata = rdata;
    case (state)
      S_IDLE: begin
        if (start && req_type == REQ_PUSH && !full) begin
          mctl.wr_en = 1'b1;
          waddr      = slot_at(head, count);
          wdata      = '{row: item_row, col: item_col, len: item_len};
        end
      end
      S_WALK: begin
        if (rd_idx < count) begin
          mctl.rd_en = 1'b1;
          raddr      = slot_at(head, rd_idx);
        end
        if (pend && rdata.row != key) begin
          mctl.wr_en = 1'b1;
          waddr      = slot_at(head, kept);
        end
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  fkr_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .ctl  (mctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer: state, queue pointers and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            removed      <= '0;
            push_dropped <= 1'b0;
            pop_empty    <= 1'b0;
            case (req_type)
              REQ_PUSH: begin
                done         <= 1'b1;
                push_dropped <= full;
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              REQ_POP: begin
                done <= 1'b1;
                if (count == '0) begin
                  pop_empty <= 1'b1;
                end else begin
                  head    <= slot_at(head, CW'(1));
                  count   <= count - CW'(1);
                  removed <= CW'(1);
                end
              end
              REQ_REMOVE: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state  <= S_WALK;
                  rd_idx <= '0;
                  kept   <= '0;
                  key    <= match_row;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          // advance the read offset, then judge the record that came back
          if (rd_idx < count) begin
            rd_idx <= rd_idx + CW'(1);
            pend   <= 1'b1;
          end
          if (pend) begin
            if (rdata.row == key) begin
              removed <= removed + CW'(1);
            end else begin
              kept <= kept + CW'(1);
            end
          end
          if (!pend && rd_idx == count) begin
            count <= kept;
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign entry_count   = 7'(count);
  assign removed_count = 7'(removed);

  `FKR_ASSERT_IMPL(a_done_not_busy, done, !busy)
  `FKR_ASSERT_IMPL(a_count_bounded, 1'b1, count <= FULL)
  `FKR_ASSERT_IMPL(a_drop_only_full, done && push_dropped, count == FULL)
  `FKR_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)
  `FKR_ASSERT_IMPL(a_walk_tally, busy,
    (CW+1)'(kept) + (CW+1)'(removed) + (CW+1)'(pend) == (CW+1)'(rd_idx))

endmodule

### bench/fifo_with_key_removal_tb.sv
// Self-checking bench for fifo_with_key_removal: drives push, pop, row-removal
// and no-op requests and checks every result against a behavioural queue.
// Depends on fkr_pkg and the fifo_with_key_removal RTL.
`timescale 1ns / 1ps

module fifo_with_key_removal_tb;
  import fkr_pkg::*;

  // Request code the package leaves unnamed: the block treats it as a no-op
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int QCAP = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [6:0] count;
    logic [6:0] removed;
    logic       dropped;
    logic       empty;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        req_type = REQ_NOP;
  logic signed [15:0] item_row = '0;
  logic signed [15:0] item_col = '0;
  logic [7:0]        item_len = '0;
  logic signed [15:0] match_row = '0;
  logic              busy;
  logic              done;
  logic [6:0]        entry_count;
  logic [6:0]        removed_count;
  logic              push_dropped;
  logic              pop_empty;

  rec_t     shadow_recs[$];
  outcome_t pending_outcomes[$];
  logic signed [15:0] row_pool[4];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;

  fifo_with_key_removal uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .item_row(item_row), .item_col(item_col),
    .item_len(item_len), .match_row(match_row),
    .done(done), .entry_count(entry_count), .removed_count(removed_count),
    .push_dropped(push_dropped), .pop_empty(pop_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Apply one accepted request to the shadow queue and work out its result
  task automatic predict_queue_op(input logic [1:0] kind, input logic [15:0] row,
                                  input logic [15:0] col, input logic [7:0] len,
                                  input logic [15:0] key, output outcome_t want);
    rec_t kept[$];
    rec_t rec;
    int   n_removed;
    want = '0;
    n_removed = 0;
    case (kind)
      REQ_PUSH: begin
        if (shadow_recs.size() >= QCAP) begin
          want.dropped = 1'b1;
        end else begin
          rec.row = row;
          rec.col = col;
          rec.len = len;
          shadow_recs.push_back(rec);
        end
      end
      REQ_POP: begin
        if (shadow_recs.size() == 0) begin
          want.empty = 1'b1;
        end else begin
          void'(shadow_recs.pop_front());
          n_removed = 1;
        end
      end
      REQ_REMOVE: begin
        foreach (shadow_recs[i]) begin
          if (shadow_recs[i].row == key) n_removed++;
          else kept.push_back(shadow_recs[i]);
        end
        shadow_recs = kept;
      end
      default: ;
    endcase
    want.removed = n_removed[6:0];
    want.count = 7'(shadow_recs.size());
  endtask

  // Present one request and hold it until the block takes it
  task automatic send_req(input logic [1:0] kind, input logic signed [15:0] row,
                          input logic signed [15:0] col, input logic [7:0] len,
                          input logic signed [15:0] key);
    outcome_t want;
    start <= 1'b1;
    req_type <= kind;
    item_row <= row;
    item_col <= col;
    item_len <= len;
    match_row <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_op(kind, row, col, len, key, want);
    pending_outcomes.push_back(want);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Bursts of requests with random gaps; now and then a long unbroken run
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      hold_off($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  function automatic logic signed [15:0] pick_row();
    return ($urandom_range(0, 9) < 8) ? row_pool[$urandom_range(0, 3)]
                                      : 16'($urandom);
  endfunction

  task automatic push_random(input logic signed [15:0] row);
    send_req(REQ_PUSH, row, 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic refresh_pool();
    foreach (row_pool[i]) row_pool[i] = 16'($urandom);
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin : check_result
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.count, entry_count);
          fail_count++;
        end
        if (removed_count !== want.removed) begin
          $display("%0t: removed_count expected %0d actual %0d",
                   $time, want.removed, removed_count);
          fail_count++;
        end
        if (push_dropped !== want.dropped) begin
          $display("%0t: push_dropped expected %0b actual %0b",
                   $time, want.dropped, push_dropped);
          fail_count++;
        end
        if (pop_empty !== want.empty) begin
          $display("%0t: pop_empty expected %0b actual %0b",
                   $time, want.empty, pop_empty);
          fail_count++;
        end
      end
    end
  end

  // Empty-queue cases, field extremes and every request code
  task automatic test_corner_requests();
    send_req(REQ_POP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    send_req(REQ_NOP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    send_req(REQ_PUSH, -16'sd32768, 16'sd32767, 8'd0, 16'sd0);
    pace_sender();
    send_req(REQ_PUSH, 16'sd32767, -16'sd32768, 8'd255, 16'sd0);
    send_req(REQ_PUSH, -16'sd32768, 16'sd0, 8'hAA, 16'sd32767);
    send_req(REQ_PUSH, 16'sd0, -16'sd1, 8'h55, -16'sd32768);
    send_req(REQ_NOP, 16'sd32767, 16'sd32767, 8'd255, 16'sd32767);
    pace_sender();
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, -16'sd32768);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, 16'sd32767);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, 16'sd5);
    send_req(REQ_POP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    send_req(REQ_POP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    pace_sender();
    send_req(REQ_PUSH, -16'sd1, 16'sd7, 8'd1, 16'sd0);
    send_req(REQ_PUSH, 16'sd2, 16'sd8, 8'd2, 16'sd0);
    send_req(REQ_PUSH, -16'sd1, 16'sd9, 8'd3, 16'sd0);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, -16'sd1);
    send_req(REQ_POP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, 16'sd2);
  endtask

  // Fill to capacity, overflow, wrap the tail, then clear a full queue in one removal
  task automatic test_fill_and_overflow();
    refresh_pool();
    while (shadow_recs.size() > 0) begin
      send_req(REQ_POP, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      pace_sender();
    end
    while (shadow_recs.size() < QCAP) begin
      push_random(row_pool[$urandom_range(0, 2)]);
      pace_sender();
    end
    push_random(pick_row());
    push_random(pick_row());
    send_req(REQ_POP, 16'sd0, 16'sd0, 8'd0, 16'sd0);
    push_random(row_pool[1]);
    pace_sender();
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, row_pool[0]);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, row_pool[1]);
    pace_sender();
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, row_pool[2]);
    while (shadow_recs.size() < QCAP) begin
      push_random(row_pool[3]);
      pace_sender();
    end
    push_random(row_pool[3]);
    send_req(REQ_REMOVE, 16'sd0, 16'sd0, 8'd0, row_pool[3]);
  endtask

  // Mixed traffic swinging between filling and draining the queue
  task automatic test_random_traffic(input int n_items);
    logic       filling;
    int         r;
    logic [1:0] kind;
    logic signed [15:0] key;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) refresh_pool();
      if (i % 350 == 349) wait_drain();
      if (shadow_recs.size() >= QCAP - 1) filling = 1'b0;
      else if (shadow_recs.size() <= 1) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (filling) kind = (r < 70) ? REQ_PUSH : (r < 84) ? REQ_POP :
                          (r < 95) ? REQ_REMOVE : REQ_NOP;
      else kind = (r < 20) ? REQ_PUSH : (r < 60) ? REQ_POP :
                  (r < 95) ? REQ_REMOVE : REQ_NOP;
      // Aim one removal in three directly at a held row
      if (shadow_recs.size() > 0 && $urandom_range(0, 2) == 0)
        key = shadow_recs[$urandom_range(0, shadow_recs.size() - 1)].row;
      else
        key = pick_row();
      send_req(kind, pick_row(), 16'($urandom), 8'($urandom), key);
      pace_sender();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_requests();
    wait_drain();
    test_fill_and_overflow();
    wait_drain();
    test_random_traffic(1450);
    wait_drain();
    repeat (QCAP + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
